@@ sv/bdl_pkg.sv @@
// shared types and codes for the bounded double-ended list
package bdl_pkg;

	// item field widths
	localparam int OP_W    = 3;
	localparam int POS_W   = 7;
	localparam int VAL_W   = 32;
	localparam int CNT_W   = 7;
	localparam int TDATA_W = 48;

	// operation codes
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_SET        = 3'd2;
	localparam logic [OP_W-1:0] OP_DELETE     = 3'd3;
	localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;
	localparam logic [OP_W-1:0] OP_READ       = 3'd5;
	localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;

	// result status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_BAD  = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_WALK,
		S_DRAIN,
		S_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic walk_init;
		logic walk_step;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic err;
		logic walk_zero;
		logic walk_last;
		logic out_free;
	} sts_t;

endpackage

@@ sv/bdl_ctrl.sv @@
// controller state machine for the bounded double-ended list
module bdl_ctrl import bdl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_nxt = S_DECODE;
			end
			S_DECODE: begin
				if (sts.err || sts.walk_zero) state_nxt = S_FINISH;
				else state_nxt = S_WALK;
			end
			S_WALK: begin
				if (sts.walk_last) state_nxt = S_DRAIN;
			end
			S_DRAIN: begin
				state_nxt = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_DECODE: begin
				cmd.walk_init = !(sts.err || sts.walk_zero);
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
			end
			S_DRAIN: begin
			end
			S_FINISH: begin
				cmd.commit = sts.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ sv/bdl_dp.sv @@
// datapath: entry memory, walk pointer, count and result register
module bdl_dp import bdl_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	input  logic [OP_W-1:0]         in_operation,
	input  logic [POS_W-1:0]        in_position,
	input  logic signed [VAL_W-1:0] in_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [VAL_W-1:0] out_read_value,
	output logic                    out_found,
	output logic [1:0]              out_status,
	output logic [CNT_W-1:0]        out_count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	logic [VAL_W-1:0] mem [DEPTH];

	logic [OP_W-1:0]         op_q;
	logic [POS_W-1:0]        pos_q;
	logic signed [VAL_W-1:0] val_q;
	logic [CW-1:0]           count_q;
	logic [AW-1:0]           ptr_q;
	logic [CW-1:0]           left_q;
	logic                    found_q;
	logic                    rvalid_s1;
	logic [AW-1:0]           raddr_s1;
	logic [VAL_W-1:0]        rdata_s1;
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] rd_q;
	logic                    found_out_q;
	logic [1:0]              status_q;
	logic [CNT_W-1:0]        count_out_q;

	logic [PW-1:0] pos_ext;
	logic [PW-1:0] cnt_ext;
	logic [PW-1:0] pos_m1;
	logic [PW-1:0] tail_len;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] count_nxt;
	logic [PW-1:0] count_nxt_ext;
	logic          is_full;
	logic          pos_ok;
	logic          err;
	logic [1:0]    status;
	logic [AW-1:0] walk_start;
	logic [CW-1:0] walk_len;
	logic          walk_up;
	logic          shifting;
	logic          shift_we;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [VAL_W-1:0] mem_wdata;

	assign pos_ext  = PW'(pos_q);
	assign cnt_ext  = PW'(count_q);
	assign pos_m1   = pos_ext - PW'(1);
	assign tail_len = cnt_ext - pos_ext;
	assign cnt_m1   = count_q - CW'(1);
	assign is_full  = (count_q == CW'(DEPTH));
	assign pos_ok   = (count_q != '0) && (pos_q != '0) && (pos_ext <= cnt_ext);
	assign shifting = (op_q == OP_PUSH_FRONT) || (op_q == OP_DELETE);
	assign walk_up  = (op_q != OP_PUSH_FRONT);
	assign shift_we = rvalid_s1 && shifting;

	// error check and walk range per operation
	always_comb begin
		err        = 1'b0;
		status     = STAT_OK;
		walk_start = '0;
		walk_len   = '0;
		case (op_q)
			OP_PUSH_FRONT: begin
				err        = is_full;
				status     = is_full ? STAT_FULL : STAT_OK;
				walk_start = cnt_m1[AW-1:0];
				walk_len   = count_q;
			end
			OP_PUSH_BACK: begin
				err    = is_full;
				status = is_full ? STAT_FULL : STAT_OK;
			end
			OP_SET: begin
				err    = !pos_ok;
				status = pos_ok ? STAT_OK : STAT_BAD;
			end
			OP_DELETE: begin
				err        = !pos_ok;
				status     = pos_ok ? STAT_OK : STAT_BAD;
				walk_start = pos_ext[AW-1:0];
				walk_len   = tail_len[CW-1:0];
			end
			OP_SEARCH: begin
				err      = (count_q == '0);
				status   = err ? STAT_BAD : STAT_OK;
				walk_len = count_q;
			end
			OP_READ: begin
				err        = !pos_ok;
				status     = pos_ok ? STAT_OK : STAT_BAD;
				walk_start = pos_m1[AW-1:0];
				walk_len   = CW'(1);
			end
			default: begin
			end
		endcase
	end

	// count after the operation
	always_comb begin
		count_nxt = count_q;
		if (!err) begin
			case (op_q) inside
				OP_PUSH_FRONT, OP_PUSH_BACK: count_nxt = count_q + CW'(1);
				OP_DELETE:                   count_nxt = cnt_m1;
				OP_CLEAR:                    count_nxt = '0;
				default:                     count_nxt = count_q;
			endcase
		end
	end
	assign count_nxt_ext = PW'(count_nxt);

	// one write port: shift moves during the walk, the final store at commit
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = val_q;
		if (shift_we) begin
			mem_we    = 1'b1;
			mem_waddr = walk_up ? (raddr_s1 - AW'(1)) : (raddr_s1 + AW'(1));
			mem_wdata = rdata_s1;
		end else if (cmd.commit && !err) begin
			case (op_q)
				OP_PUSH_FRONT: begin
					mem_we    = 1'b1;
					mem_waddr = '0;
				end
				OP_PUSH_BACK: begin
					mem_we    = 1'b1;
					mem_waddr = cnt_ext[AW-1:0];
				end
				OP_SET: begin
					mem_we    = 1'b1;
					mem_waddr = pos_m1[AW-1:0];
				end
				default: mem_we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (cmd.walk_step) rdata_s1 <= mem[ptr_q];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_operation;
			pos_q <= in_position;
			val_q <= in_value;
		end
		if (cmd.walk_init) begin
			ptr_q <= walk_start;
		end else if (cmd.walk_step) begin
			ptr_q <= walk_up ? (ptr_q + AW'(1)) : (ptr_q - AW'(1));
		end
		if (cmd.walk_step) raddr_s1 <= ptr_q;
		if (cmd.commit) begin
			rd_q        <= (op_q == OP_READ && !err) ? $signed(rdata_s1) : '0;
			found_out_q <= found_q;
			status_q    <= status;
			count_out_q <= count_nxt_ext[CNT_W-1:0];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			left_q      <= '0;
			rvalid_s1   <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rvalid_s1 <= cmd.walk_step;
			if (cmd.commit) count_q <= count_nxt;
			if (cmd.walk_init) begin
				left_q <= walk_len;
			end else if (cmd.walk_step) begin
				left_q <= left_q - CW'(1);
			end
			if (cmd.load) begin
				found_q <= 1'b0;
			end else if (rvalid_s1 && op_q == OP_SEARCH && $signed(rdata_s1) == val_q) begin
				found_q <= 1'b1;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.err       = err;
	assign sts.walk_zero = (walk_len == '0);
	assign sts.walk_last = (left_q == CW'(1));
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign out_read_value = rd_q;
	assign out_found      = found_out_q;
	assign out_status     = status_q;
	assign out_count      = count_out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(shift_we && cmd.commit))
		else $error("shift write collides with final store");

	a_count_only_at_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit |=> $stable(count_q))
		else $error("count changed outside commit");

	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while pending");

endmodule

@@ sv/bounded_double_ended_list_core.sv @@
// top level of the bounded double-ended list
//
// channel  dir  handshake          tdata fields (lowest bit up)
// s_axis   in   s_tvalid/s_tready  operation[2:0] position[9:3] value[41:10]
// m_axis   out  m_tvalid/m_tready  read_value[31:0] found[32] status[34:33] count[41:35]
//
// one item at a time; a beat is taken only when the controller is idle
// result is registered at commit in the finish state, reached straight from decode when
//   nothing is walked, else via walk and drain (push front walks all entries, delete the
//   tail past the position, search all entries, read one); next beat is taken in idle
// the walk is set by the entry memory, one registered read and one write a cycle
// reset clears the count and handshake state; entry contents are left as they are
// a pending result in the output register does not block the next input beat;
// the following result waits in its final state until that register drains
module bounded_double_ended_list_core import bdl_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,  // operation, position, value, zero pad
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata   // read_value, found, status, count, zero pad
);

	cmd_t cmd;
	sts_t sts;

	logic signed [VAL_W-1:0] read_value;
	logic                    found;
	logic [1:0]              status;
	logic [CNT_W-1:0]        count;

	// sequencer: idle, decode, walk, drain, finish
	bdl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// entry memory, count and result register
	bdl_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_operation   (s_tdata[2:0]),
		.in_position    (s_tdata[9:3]),
		.in_value       ($signed(s_tdata[41:10])),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_read_value (read_value),
		.out_found      (found),
		.out_status     (status),
		.out_count      (count)
	);

	// result beat packing, upper bits padded with zeros
	assign m_tdata = {6'b0, count, status, found, read_value};

endmodule
